/* hw/rtl/pmm_pkg.sv */
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the pin matrix modulator
// sample, term and result types, cell op codes, register indexes, widths
// ----------------------------------------------------------------------------
`default_nettype none

package pmm_pkg;

   localparam int N_CH      = 3;
   localparam int N_CELL    = N_CH * N_CH;
   localparam int N_PAIR    = 6;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int TERM_W    = 22;
   localparam int SUM_W     = 24;
   localparam int OUT_W     = 24;
   localparam int FRAC_BITS = 10;

   localparam int TOP_OPS_W = 2 * N_CELL;
   localparam int MASK_W    = N_CELL;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   // divide by three: q = (mag * RECIP3) >> RECIP_SHIFT, exact for mag < 2**23
   localparam int MAG_W       = 22;
   localparam int RECIP_SHIFT = 23;
   localparam logic [MAG_W-1:0] RECIP3 = MAG_W'(2796203);
   localparam int QUOT_W      = 2 * MAG_W - RECIP_SHIFT;

   // cell op codes
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_SUB  = 2'd2;
   localparam logic [1:0] OP_MUL  = 2'd3;

   // register indexes
   localparam logic REG_TOP_OPS     = 1'b0;
   localparam logic REG_BOTTOM_MASK = 1'b1;

   // unordered channel pairs: products a_i * a_j are shared by cells (i,j) and (j,i)
   localparam int PAIR_LO [N_PAIR] = '{0, 0, 0, 1, 1, 2};
   localparam int PAIR_HI [N_PAIR] = '{0, 1, 2, 1, 2, 2};
   localparam int CELL_PAIR [N_CELL] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [TERM_W-1:0]   term_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [OUT_W-1:0]    out_type;

   typedef struct packed {
      sample_type [N_CH-1:0] top;
      sample_type [N_CH-1:0] bot;
   } frame_type;

   typedef struct packed {
      logic [TOP_OPS_W-1:0] top_ops;
      logic [MASK_W-1:0]    bottom_mask;
   } cfg_type;

   typedef struct packed {
      term_type   [N_CELL-1:0] top;
      sample_type [N_CELL-1:0] bot;
   } terms_type;

   typedef struct packed {
      out_type [N_CH-1:0] top_row;
      out_type            top_total;
      out_type [N_CH-1:0] bot_row;
      out_type            bot_total;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/pin_matrix_modulator_unit.sv */
// ----------------------------------------------------------------------------
// pin_matrix_modulator_unit: two-section 3x3 matrix modulator
// top section combines channel pairs by per-cell op codes, bottom section
// averages masked channels; each row is divided by three, plus a total
//
//   channel   handshake            word
//   -------   ------------------   -------------------------------------
//   request   start / busy         three top and three bottom samples,
//                                  connected flags for each group
//   response  rsp_strobe           three top rows, top total,
//                                  three bottom rows, bottom total
//   config    psel/penable/pwrite  top_ops at 0x0, bottom_mask at 0x4
//
// one word is taken every cycle; busy stays low
// the response strobe comes from the result register; a word passes the input
// register, cell register (products and op select), row-sum register, then
// the result register after the divide by three and the totals
// the receiver cannot stall, so the pipeline never holds
// synchronous reset clears the valid chain and both config registers
// ----------------------------------------------------------------------------
`default_nettype none

module pin_matrix_modulator_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire pmm_pkg::sample_type           req_top_a,
   input  wire pmm_pkg::sample_type           req_top_b,
   input  wire pmm_pkg::sample_type           req_top_c,
   input  wire logic [pmm_pkg::N_CH-1:0]      req_top_present,
   input  wire pmm_pkg::sample_type           req_bot_a,
   input  wire pmm_pkg::sample_type           req_bot_b,
   input  wire pmm_pkg::sample_type           req_bot_c,
   input  wire logic [pmm_pkg::N_CH-1:0]      req_bot_present,
   // response channel
   output logic                               rsp_strobe,
   output pmm_pkg::out_type                   rsp_top_row_a,
   output pmm_pkg::out_type                   rsp_top_row_b,
   output pmm_pkg::out_type                   rsp_top_row_c,
   output pmm_pkg::out_type                   rsp_top_total,
   output pmm_pkg::out_type                   rsp_bot_row_a,
   output pmm_pkg::out_type                   rsp_bot_row_b,
   output pmm_pkg::out_type                   rsp_bot_row_c,
   output pmm_pkg::out_type                   rsp_bot_total,
   // config port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pmm_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [pmm_pkg::DATA_W-1:0]    pwdata,
   output logic      [pmm_pkg::DATA_W-1:0]    prdata,
   output logic                               pready
);
   import pmm_pkg::*;

   cfg_type    cfg;
   frame_type  frame_in, frame_ff;
   logic       frame_valid_ff;
   logic       accept;
   logic       terms_valid;
   terms_type  terms;
   logic       result_valid;
   result_type result;

   // fully pipelined: never back-pressures the requester
   assign busy   = 1'b0;
   assign accept = start & ~busy;
   // no wait states on the config port
   assign pready = 1'b1;

   pmm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // unconnected channels are zeroed on the way into the input register
   always_comb begin
      frame_in.top[0] = req_top_present[0] ? req_top_a : '0;
      frame_in.top[1] = req_top_present[1] ? req_top_b : '0;
      frame_in.top[2] = req_top_present[2] ? req_top_c : '0;
      frame_in.bot[0] = req_bot_present[0] ? req_bot_a : '0;
      frame_in.bot[1] = req_bot_present[1] ? req_bot_b : '0;
      frame_in.bot[2] = req_bot_present[2] ? req_bot_c : '0;
   end

   // input register
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else begin
         frame_valid_ff <= accept;
      end
   end

   // cell terms: products and op select
   pmm_cell u_cell (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_valid_ff),
      .frame     (frame_ff),
      .cfg       (cfg),
      .out_valid (terms_valid),
      .terms     (terms)
   );

   // row sums, divide by three, totals
   pmm_row u_row (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (terms_valid),
      .terms     (terms),
      .out_valid (result_valid),
      .result    (result)
   );

   // response word straight from the result register
   assign rsp_strobe    = result_valid;
   assign rsp_top_row_a = result.top_row[0];
   assign rsp_top_row_b = result.top_row[1];
   assign rsp_top_row_c = result.top_row[2];
   assign rsp_top_total = result.top_total;
   assign rsp_bot_row_a = result.bot_row[0];
   assign rsp_bot_row_b = result.bot_row[1];
   assign rsp_bot_row_c = result.bot_row[2];
   assign rsp_bot_total = result.bot_total;

endmodule

`default_nettype wire

/* hw/rtl/pmm_csr.sv */
// ----------------------------------------------------------------------------
// pmm_csr: configuration registers
// apb-style write and read of the top op codes and the bottom mask
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [pmm_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [pmm_pkg::DATA_W-1:0]   pwdata,
   output logic      [pmm_pkg::DATA_W-1:0]   prdata,
   output pmm_pkg::cfg_type                  cfg
);
   import pmm_pkg::*;

   logic [TOP_OPS_W-1:0] top_ops_ff, top_ops_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic                 wr_en;
   logic                 reg_sel;

   // word address: byte offset bits are ignored
   assign reg_sel = paddr[ADDR_W-1];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      top_ops_in = top_ops_ff;
      mask_in    = mask_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TOP_OPS:     top_ops_in = pwdata[TOP_OPS_W-1:0];
            REG_BOTTOM_MASK: mask_in    = pwdata[MASK_W-1:0];
            default: begin
               top_ops_in = top_ops_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ops_ff <= '0;
         mask_ff    <= '0;
      end else begin
         top_ops_ff <= top_ops_in;
         mask_ff    <= mask_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TOP_OPS:     prdata = DATA_W'(top_ops_ff);
         REG_BOTTOM_MASK: prdata = DATA_W'(mask_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.top_ops     = top_ops_ff;
   assign cfg.bottom_mask = mask_ff;

endmodule

`default_nettype wire

/* hw/rtl/pmm_cell.sv */
// ----------------------------------------------------------------------------
// pmm_cell: matrix cell stage
// forms the nine top cell terms and nine masked bottom terms, registered
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire pmm_pkg::frame_type   frame,
   input  wire pmm_pkg::cfg_type     cfg,
   output logic                      out_valid,
   output pmm_pkg::terms_type        terms
);
   import pmm_pkg::*;

   sample_type              ta [N_CH];
   sample_type              tb [N_CH];
   logic signed [PROD_W-1:0] prod [N_PAIR];
   terms_type               terms_in, terms_ff;
   logic                    valid_ff;

   always_comb begin
      for (int i = 0; i < N_CH; i++) begin
         ta[i] = frame.top[i];
         tb[i] = frame.bot[i];
      end
      // six distinct products cover all nine cells
      for (int p = 0; p < N_PAIR; p++) begin
         prod[p] = PROD_W'(ta[PAIR_LO[p]]) * PROD_W'(ta[PAIR_HI[p]]);
      end
   end

   always_comb begin
      int                       k;
      logic [1:0]               code;
      logic signed [PROD_W-1:0] shifted;
      k        = 0;
      code     = OP_NONE;
      shifted  = '0;
      terms_in = '0;
      for (int i = 0; i < N_CH; i++) begin
         for (int j = 0; j < N_CH; j++) begin
            k       = i * N_CH + j;
            code    = cfg.top_ops[2*k +: 2];
            // arithmetic shift floors toward minus infinity
            shifted = prod[CELL_PAIR[k]] >>> FRAC_BITS;
            case (code)
               OP_ADD:  terms_in.top[k] = TERM_W'(ta[i]) + TERM_W'(ta[j]);
               OP_SUB:  terms_in.top[k] = TERM_W'(ta[i]) - TERM_W'(ta[j]);
               OP_MUL:  terms_in.top[k] = shifted[TERM_W-1:0];
               default: terms_in.top[k] = '0;
            endcase
            terms_in.bot[k] = cfg.bottom_mask[k] ? tb[j] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      terms_ff <= terms_in;
   end

   assign out_valid = valid_ff;
   assign terms     = terms_ff;

endmodule

`default_nettype wire

/* hw/rtl/pmm_row.sv */
// ----------------------------------------------------------------------------
// pmm_row: row reduction stages
// row sums, then divide by three toward zero and the two totals
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_row (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire pmm_pkg::terms_type   terms,
   output logic                      out_valid,
   output pmm_pkg::result_type       result
);
   import pmm_pkg::*;

   sum_type    top_sum_in [N_CH];
   sum_type    bot_sum_in [N_CH];
   sum_type    top_sum_ff [N_CH];
   sum_type    bot_sum_ff [N_CH];
   logic       sum_valid_ff;
   result_type result_in, result_ff;
   logic       result_valid_ff;

   // magnitude times reciprocal, sign put back: truncation toward zero
   function automatic out_type div3(input sum_type s);
      logic [MAG_W-1:0]   mag;
      logic [2*MAG_W-1:0] wide;
      logic [QUOT_W-1:0]  q;
      mag  = s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
      wide = (2*MAG_W)'(mag) * (2*MAG_W)'(RECIP3);
      q    = wide[2*MAG_W-1:RECIP_SHIFT];
      return s[SUM_W-1] ? -OUT_W'(q) : OUT_W'(q);
   endfunction

   always_comb begin
      for (int i = 0; i < N_CH; i++) begin
         top_sum_in[i] = SUM_W'(terms.top[i*N_CH])
                       + SUM_W'(terms.top[i*N_CH+1])
                       + SUM_W'(terms.top[i*N_CH+2]);
         bot_sum_in[i] = SUM_W'(terms.bot[i*N_CH])
                       + SUM_W'(terms.bot[i*N_CH+1])
                       + SUM_W'(terms.bot[i*N_CH+2]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_CH; i++) begin
         top_sum_ff[i] <= top_sum_in[i];
         bot_sum_ff[i] <= bot_sum_in[i];
      end
   end

   always_comb begin
      for (int i = 0; i < N_CH; i++) begin
         result_in.top_row[i] = div3(top_sum_ff[i]);
         result_in.bot_row[i] = div3(bot_sum_ff[i]);
      end
      result_in.top_total = result_in.top_row[0] + result_in.top_row[1]
                          + result_in.top_row[2];
      result_in.bot_total = result_in.bot_row[0] + result_in.bot_row[1]
                          + result_in.bot_row[2];
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff    <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff    <= in_valid;
         result_valid_ff <= sum_valid_ff;
      end
   end

   assign out_valid = result_valid_ff;
   assign result    = result_ff;

endmodule

`default_nettype wire

/* test/pmm_frame_checker.sv */
// ----------------------------------------------------------------------------
// pmm_frame_checker: scoreboard for the pin matrix modulator
// tracks config writes, predicts the mix of every accepted request word and
// compares each response word field by field against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module pmm_frame_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire pmm_pkg::sample_type           req_top_a,
   input  wire pmm_pkg::sample_type           req_top_b,
   input  wire pmm_pkg::sample_type           req_top_c,
   input  wire logic [pmm_pkg::N_CH-1:0]      req_top_present,
   input  wire pmm_pkg::sample_type           req_bot_a,
   input  wire pmm_pkg::sample_type           req_bot_b,
   input  wire pmm_pkg::sample_type           req_bot_c,
   input  wire logic [pmm_pkg::N_CH-1:0]      req_bot_present,
   input  wire logic                          rsp_strobe,
   input  wire pmm_pkg::out_type              rsp_top_row_a,
   input  wire pmm_pkg::out_type              rsp_top_row_b,
   input  wire pmm_pkg::out_type              rsp_top_row_c,
   input  wire pmm_pkg::out_type              rsp_top_total,
   input  wire pmm_pkg::out_type              rsp_bot_row_a,
   input  wire pmm_pkg::out_type              rsp_bot_row_b,
   input  wire pmm_pkg::out_type              rsp_bot_row_c,
   input  wire pmm_pkg::out_type              rsp_bot_total,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pmm_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [pmm_pkg::DATA_W-1:0]    pwdata,
   input  wire logic                          pready,
   output int                                 mismatches,
   output int                                 pending
);
   import pmm_pkg::*;

   localparam logic [ADDR_W-1:0] TOP_OPS_ADDR     = {REG_TOP_OPS, 2'b00};
   localparam logic [ADDR_W-1:0] BOTTOM_MASK_ADDR = {REG_BOTTOM_MASK, 2'b00};

   logic [TOP_OPS_W-1:0] cell_ops;
   logic [MASK_W-1:0]    cell_mask;
   result_type           due_results [$];
   result_type           want;

   function automatic result_type mix_frame(input sample_type [N_CH-1:0] top_in,
                                            input logic [N_CH-1:0] top_pres,
                                            input sample_type [N_CH-1:0] bot_in,
                                            input logic [N_CH-1:0] bot_pres);
      longint     ta [N_CH];
      longint     ba [N_CH];
      longint     ts, bs, tr, br, term, ttot, btot;
      sample_type s;
      logic [1:0] code;
      int         k;
      result_type r;
      ttot = 0;
      btot = 0;
      for (int i = 0; i < N_CH; i++) begin
         s = top_in[i];
         ta[i] = top_pres[i] ? longint'(s) : 0;
         s = bot_in[i];
         ba[i] = bot_pres[i] ? longint'(s) : 0;
      end
      for (int i = 0; i < N_CH; i++) begin
         ts = 0;
         bs = 0;
         for (int j = 0; j < N_CH; j++) begin
            k = i * N_CH + j;
            code = cell_ops[2*k +: 2];
            case (code)
               OP_ADD:  term = ta[i] + ta[j];
               OP_SUB:  term = ta[i] - ta[j];
               OP_MUL:  term = (ta[i] * ta[j]) >>> FRAC_BITS;   // floor
               default: term = 0;
            endcase
            ts += term;
            if (cell_mask[k]) bs += ba[j];
         end
         tr = ts / 3;   // truncates toward zero
         br = bs / 3;
         ttot += tr;
         btot += br;
         r.top_row[i] = tr[OUT_W-1:0];
         r.bot_row[i] = br[OUT_W-1:0];
      end
      r.top_total = ttot[OUT_W-1:0];
      r.bot_total = btot[OUT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input out_type exp_v, input out_type got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cell_ops  = '0;
         cell_mask = '0;
         due_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == TOP_OPS_ADDR)     cell_ops  = pwdata[TOP_OPS_W-1:0];
            if (paddr == BOTTOM_MASK_ADDR) cell_mask = pwdata[MASK_W-1:0];
         end
         if (start && !busy)
            due_results.push_back(mix_frame({req_top_c, req_top_b, req_top_a}, req_top_present,
                                            {req_bot_c, req_bot_b, req_bot_a}, req_bot_present));
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               $error("response word with nothing expected");
               mismatches++;
            end else begin
               want = due_results.pop_front();
               check_field("top_row_a", want.top_row[0], rsp_top_row_a);
               check_field("top_row_b", want.top_row[1], rsp_top_row_b);
               check_field("top_row_c", want.top_row[2], rsp_top_row_c);
               check_field("top_total", want.top_total,  rsp_top_total);
               check_field("bot_row_a", want.bot_row[0], rsp_bot_row_a);
               check_field("bot_row_b", want.bot_row[1], rsp_bot_row_b);
               check_field("bot_row_c", want.bot_row[2], rsp_bot_row_c);
               check_field("bot_total", want.bot_total,  rsp_bot_total);
            end
         end
      end
      pending = due_results.size();
   end

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top for pin_matrix_modulator_unit
// drives request words and config writes with random gaps, a directed pass
// over extremes and every cell op, then randomized phases with fresh configs;
// a separate checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import pmm_pkg::*;

   localparam int LATENCY     = 3;      // accepting edge to response strobe
   localparam int STALL_LIMIT = 2000;   // idle cycles before the watchdog fires
   localparam int N_PHASES    = 12;
   localparam int PHASE_WORDS = 64;

   localparam logic [ADDR_W-1:0] TOP_OPS_ADDR     = {REG_TOP_OPS, 2'b00};
   localparam logic [ADDR_W-1:0] BOTTOM_MASK_ADDR = {REG_BOTTOM_MASK, 2'b00};

   // uniform op words: the same code in all nine cells
   localparam logic [TOP_OPS_W-1:0] ALL_ADD = {N_CELL{OP_ADD}};
   localparam logic [TOP_OPS_W-1:0] ALL_SUB = {N_CELL{OP_SUB}};
   localparam logic [TOP_OPS_W-1:0] ALL_MUL = {N_CELL{OP_MUL}};
   // every op somewhere, cell 8 first
   localparam logic [TOP_OPS_W-1:0] MIXED_OPS =
      {OP_NONE, OP_MUL, OP_MUL, OP_SUB, OP_ADD, OP_MUL, OP_SUB, OP_ADD, OP_NONE};

   localparam sample_type S_MAX = 16'sh7FFF;
   localparam sample_type S_MIN = 16'sh8000;
   localparam sample_type S_NEG = -16'sd1;
   localparam sample_type S_ZERO = 16'sd0;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   sample_type          req_top_a, req_top_b, req_top_c;
   logic [N_CH-1:0]     req_top_present;
   sample_type          req_bot_a, req_bot_b, req_bot_c;
   logic [N_CH-1:0]     req_bot_present;
   logic                rsp_strobe;
   out_type             rsp_top_row_a, rsp_top_row_b, rsp_top_row_c, rsp_top_total;
   out_type             rsp_bot_row_a, rsp_bot_row_b, rsp_bot_row_c, rsp_bot_total;
   logic                psel, penable, pwrite, pready;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata, prdata;
   int                  fail_count;
   int                  words_due;
   int                  stall_cycles;
   bit                  burst;

   pin_matrix_modulator_unit uut (
      .clock, .reset,
      .start, .busy,
      .req_top_a, .req_top_b, .req_top_c, .req_top_present,
      .req_bot_a, .req_bot_b, .req_bot_c, .req_bot_present,
      .rsp_strobe,
      .rsp_top_row_a, .rsp_top_row_b, .rsp_top_row_c, .rsp_top_total,
      .rsp_bot_row_a, .rsp_bot_row_b, .rsp_bot_row_c, .rsp_bot_total,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   pmm_frame_checker u_checker (
      .clock, .reset,
      .start, .busy,
      .req_top_a, .req_top_b, .req_top_c, .req_top_present,
      .req_bot_a, .req_bot_b, .req_bot_c, .req_bot_present,
      .rsp_strobe,
      .rsp_top_row_a, .rsp_top_row_b, .rsp_top_row_c, .rsp_top_total,
      .rsp_bot_row_a, .rsp_bot_row_b, .rsp_bot_row_c, .rsp_bot_total,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatches(fail_count),
      .pending(words_due)
   );

   // 2 time unit clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // watchdog: any accepted word, response strobe or config write restarts the count
   initial stall_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable && pwrite && pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // sample picker, weighted toward the corners of the range
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return S_ZERO;
         3:       return S_NEG;
         4:       return sample_type'($urandom_range(0, 200) - 100);
         default: return sample_type'($urandom());
      endcase
   endfunction

   // mostly all channels connected, sometimes any mix
   function automatic logic [N_CH-1:0] pick_present();
      if ($urandom_range(0, 3) == 0) return N_CH'($urandom_range(0, 7));
      return '1;
   endfunction

   // present one request word, called at a falling edge, returns at a falling edge once the word is taken
   task automatic put_frame(input sample_type ta, input sample_type tb_s, input sample_type tc,
                            input logic [N_CH-1:0] tp,
                            input sample_type ba, input sample_type bb, input sample_type bc,
                            input logic [N_CH-1:0] bp);
      start           = 1'b1;
      req_top_a       = ta;
      req_top_b       = tb_s;
      req_top_c       = tc;
      req_top_present = tp;
      req_bot_a       = ba;
      req_bot_b       = bb;
      req_bot_c       = bc;
      req_bot_present = bp;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle(input int n);
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random gap after a word: none in a burst, else mostly none or short, now and then long
   task automatic gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return;
      if (r < 90) idle($urandom_range(1, 3));
      else        idle($urandom_range(10, 40));
   endtask

   // wait until every expected response word has arrived, then let the pipe settle
   task automatic drain();
      start = 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   // two-phase config write, block must be idle
   task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic [DATA_W-1:0] ops, input logic [DATA_W-1:0] mask);
      drain();
      write_reg(TOP_OPS_ADDR, ops);
      write_reg(BOTTOM_MASK_ADDR, mask);
   endtask

   task automatic random_frame();
      put_frame(pick_sample(), pick_sample(), pick_sample(), pick_present(),
                pick_sample(), pick_sample(), pick_sample(), pick_present());
      gap();
   endtask

   initial begin
      logic [DATA_W-1:0] ops_word, mask_word;

      // every input known from time zero
      reset           = 1'b1;
      start           = 1'b0;
      req_top_a       = '0;
      req_top_b       = '0;
      req_top_c       = '0;
      req_top_present = '0;
      req_bot_a       = '0;
      req_bot_b       = '0;
      req_bot_c       = '0;
      req_bot_present = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      burst           = 1'b1;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      // reset config: every cell none, mask clear, all outputs zero
      put_frame(S_MAX, S_MAX, S_MAX, 3'b111, S_MAX, S_MAX, S_MAX, 3'b111);
      put_frame(S_MIN, S_MIN, S_MIN, 3'b111, S_MIN, S_MIN, S_MIN, 3'b111);

      // all multiply, full mask; upper data bits set to show they are dropped
      set_config('1, '1);
      put_frame(S_MAX, S_MAX, S_MAX, 3'b111, S_MAX, S_MAX, S_MAX, 3'b111);
      put_frame(S_MIN, S_MIN, S_MIN, 3'b111, S_MIN, S_MIN, S_MIN, 3'b111);
      put_frame(S_MAX, S_MIN, S_MAX, 3'b111, S_MIN, S_MAX, S_MIN, 3'b111);
      put_frame(S_ZERO, S_ZERO, S_ZERO, 3'b111, S_ZERO, S_ZERO, S_ZERO, 3'b111);
      // negative product floors away from zero
      put_frame(S_NEG, 16'sd1, S_NEG, 3'b111, S_NEG, S_NEG, S_NEG, 3'b111);
      // unconnected channels read as zero
      put_frame(S_MAX, S_MAX, S_MAX, 3'b000, S_MAX, S_MAX, S_MAX, 3'b000);
      put_frame(S_MIN, S_MAX, S_MIN, 3'b101, S_MAX, S_MIN, S_MAX, 3'b010);

      // all add, checkerboard mask
      set_config(DATA_W'(ALL_ADD), DATA_W'(9'h155));
      put_frame(S_MAX, S_MAX, S_MAX, 3'b111, S_MAX, S_MAX, S_MAX, 3'b111);
      put_frame(S_MIN, S_MIN, S_MIN, 3'b111, S_MIN, S_MIN, S_MIN, 3'b111);
      put_frame(S_MAX, S_MIN, S_NEG, 3'b011, S_MIN, S_NEG, S_MAX, 3'b110);

      // all subtract, partial mask
      set_config(DATA_W'(ALL_SUB), DATA_W'(9'h0AA));
      put_frame(S_MAX, S_MIN, S_MAX, 3'b111, S_MIN, S_MAX, S_MIN, 3'b111);
      put_frame(S_MIN, S_MAX, S_MIN, 3'b111, S_MAX, S_MAX, S_MAX, 3'b111);

      // every op code in one matrix
      set_config(DATA_W'(MIXED_OPS), DATA_W'(9'h1C7));
      put_frame(S_MAX, S_MIN, S_NEG, 3'b111, S_MIN, S_MIN, S_MAX, 3'b111);
      put_frame(S_MIN, S_MAX, S_MAX, 3'b111, S_MAX, S_NEG, S_MIN, 3'b111);
      put_frame(16'sd1234, -16'sd777, 16'sd3, 3'b110, 16'sd5, -16'sd5, 16'sd9, 3'b101);

      // ---- random phases, each with a fresh config ----
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0:       begin ops_word = DATA_W'(ALL_MUL); mask_word = DATA_W'(9'h1FF); end
            1:       begin ops_word = '0;               mask_word = '0;              end
            2:       begin ops_word = DATA_W'(ALL_ADD); mask_word = '1;              end
            3:       begin ops_word = DATA_W'(ALL_SUB); mask_word = $urandom();      end
            default: begin ops_word = $urandom();       mask_word = $urandom();      end
         endcase
         set_config(ops_word, mask_word);
         // some phases run back to back with no gaps at all
         burst = ($urandom_range(0, 2) == 0);
         for (int n = 0; n < PHASE_WORDS; n++) random_frame();
      end

      drain();
      if (fail_count == 0 && words_due == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/pmm_pkg.sv
hw/rtl/pmm_csr.sv
hw/rtl/pmm_cell.sv
hw/rtl/pmm_row.sv
hw/rtl/pin_matrix_modulator_unit.sv
test/pmm_frame_checker.sv
test/tb.sv
